>>> hw/rtl/complex_basis_transform_core_assert.svh
// Assertion macros used by the port checker file.
// Each macro expects clk and arst_n in scope.
`ifndef COMPLEX_BASIS_TRANSFORM_CORE_ASSERT_SVH
`define COMPLEX_BASIS_TRANSFORM_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define CBT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define CBT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/cbt_pkg.sv
package cbt_pkg;

	// Field widths
	localparam int ROW_W   = 4;
	localparam int VAL_W   = 16;
	localparam int RES_W   = 24;
	localparam int OIDX_W  = 4;

	// Configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam logic [CFG_IDX_W-1:0] CFG_DIRECTION = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 1'd1;
	localparam logic [CFG_DATA_W-1:0] SIZE_RESET   = 5'd16;

	// Operation codes
	localparam logic OP_BASIS  = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// Direction codes
	localparam logic DIR_FORWARD = 1'b0;
	localparam logic DIR_INVERSE = 1'b1;

	// Status codes
	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// Saturation limits of a result
	localparam logic [RES_W-1:0] SAT_MAX = 24'h7FFFFF;
	localparam logic [RES_W-1:0] SAT_MIN = 24'h800000;

	typedef struct packed {
		logic                    operation;
		logic [ROW_W-1:0]        row;
		logic [ROW_W-1:0]        col;
		logic signed [VAL_W-1:0] value_re;
		logic signed [VAL_W-1:0] value_im;
		logic                    last;
	} in_item_t;

	typedef struct packed {
		logic signed [RES_W-1:0] out_re;
		logic signed [RES_W-1:0] out_im;
		logic [OIDX_W-1:0]       out_index;
		logic                    out_last;
		logic                    status;
	} out_item_t;

	// Tag that travels with one multiply-accumulate step
	typedef struct packed {
		logic valid;
		logic first;
		logic last_term;
	} mac_tag_t;

	// Finished sum, rounded and saturated
	typedef struct packed {
		logic                    done;
		logic signed [RES_W-1:0] re;
		logic signed [RES_W-1:0] im;
	} mac_res_t;

endpackage

>>> hw/rtl/cbt_mac.sv
module cbt_mac #(
	parameter int MAX_POINTS = 16,
	parameter int SW         = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cbt_pkg::mac_tag_t tag_s1,
	input  logic [31:0]       b_word_s1,
	input  logic [2*SW-1:0]   x_word_s1,
	input  logic              inverse,
	input  logic              clear,
	output cbt_pkg::mac_res_t res
);
	import cbt_pkg::*;

	localparam int ACC_MIN = 34 + $clog2(MAX_POINTS);
	localparam int ACC_W   = (ACC_MIN > 40) ? ACC_MIN : 40;
	localparam int Q_W     = ACC_W - 15;
	localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(24'sh7FFFFF);
	localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

	logic signed [VAL_W-1:0] br, bi, xr, xi;
	logic signed [31:0]      rr_s2, ii_s2, ri_s2, ir_s2;
	mac_tag_t                tag_s2;
	logic signed [ACC_W-1:0] acc_re_q, acc_im_q, base_re, base_im;
	logic signed [ACC_W-1:0] biased_re, biased_im;
	logic signed [Q_W-1:0]   q_re, q_im;
	logic                    done_q;

	// Split operands; samples are sign extended from their stored width
	assign br = signed'(b_word_s1[31:16]);
	assign bi = signed'(b_word_s1[15:0]);
	assign xr = VAL_W'(signed'(x_word_s1[2*SW-1:SW]));
	assign xi = VAL_W'(signed'(x_word_s1[SW-1:0]));

	// Register the four partial products
	always_ff @(posedge clk) begin
		rr_s2 <= br * xr;
		ii_s2 <= bi * xi;
		ri_s2 <= br * xi;
		ir_s2 <= bi * xr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	// Restart the sum on the first term of a result
	assign base_re = tag_s2.first ? '0 : acc_re_q;
	assign base_im = tag_s2.first ? '0 : acc_im_q;

	// Accumulate; forward conjugates the basis entry
	always_ff @(posedge clk) begin
		if (tag_s2.valid) begin
			if (inverse == DIR_INVERSE) begin
				acc_re_q <= base_re + ACC_W'(rr_s2) - ACC_W'(ii_s2);
				acc_im_q <= base_im + ACC_W'(ri_s2) + ACC_W'(ir_s2);
			end else begin
				acc_re_q <= base_re + ACC_W'(rr_s2) + ACC_W'(ii_s2);
				acc_im_q <= base_im + ACC_W'(ri_s2) - ACC_W'(ir_s2);
			end
		end
	end

	// Flag a finished sum until the sequencer takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else if (clear) begin
			done_q <= 1'b0;
		end else if (tag_s2.valid && tag_s2.last_term) begin
			done_q <= 1'b1;
		end
	end

	// Round half up by 15 bits, then saturate to the result width
	assign biased_re = acc_re_q + ACC_W'(16384);
	assign biased_im = acc_im_q + ACC_W'(16384);
	assign q_re      = Q_W'(biased_re >>> 15);
	assign q_im      = Q_W'(biased_im >>> 15);

	always_comb begin
		res.done = done_q;
		if (q_re > Q_MAX) begin
			res.re = SAT_MAX;
		end else if (q_re < Q_MIN) begin
			res.re = SAT_MIN;
		end else begin
			res.re = q_re[RES_W-1:0];
		end
		if (q_im > Q_MAX) begin
			res.im = SAT_MAX;
		end else if (q_im < Q_MIN) begin
			res.im = SAT_MIN;
		end else begin
			res.im = q_im[RES_W-1:0];
		end
	end

endmodule

>>> hw/rtl/complex_basis_transform_core.sv
// Complex basis transform core: multiplies a collected complex vector by an
// N x N complex basis, conjugate-transposed (direction 0) or direct (1).
// Input channel (in_valid/in_stall/in_data) carries two kinds of transfer:
// basis writes (operation 0, one entry at row/col) and vector samples
// (operation 1). The sample with last set closes the vector. Each input
// transfer is taken only while the core is idle.
// Once a vector closes, in_stall stays high until all its results have been
// handed to the output register. With N = size_in_use, the core produces N
// results on out_valid/out_stall, one per output index; each is built by
// issuing its N terms through the registered basis and vector reads, the
// product registers and the accumulator, and the next is started only once
// the sum has been taken. The single complex multiply-accumulate unit, fed
// by one basis memory read port, sets the pace of a run.
// A vector whose length differs from size_in_use, or a size of 0 or above
// MAX_POINTS, gives one result with status 1, and nothing is computed.
// The output register holds a result under out_stall; the core waits for it
// before writing the next one, and accepts new input once the last result of
// a run sits in the output register. Reset clears control and configuration
// (direction 0, size 16); basis and vector contents are undefined until
// written, and no clearing pass is run.
module complex_basis_transform_core #(
	parameter int MAX_POINTS  = 16,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  cbt_pkg::in_item_t                 in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output cbt_pkg::out_item_t                out_data,
	input  logic                              cfg_we,
	input  logic [cbt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [cbt_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import cbt_pkg::*;

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 2);
	localparam int LEN_W = (CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W;
	localparam int AW    = $clog2(MAX_POINTS * MAX_POINTS);
	localparam int SW    = (SAMPLE_BITS < VAL_W) ? SAMPLE_BITS : VAL_W;
	localparam int DEPTH = MAX_POINTS * MAX_POINTS;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_ISSUE = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_ERR   = 2'd3;

	logic [1:0]            state_q;
	logic                  direction_q;
	logic [CFG_DATA_W-1:0] size_q;
	logic [CNT_W-1:0]      count_q, count_nxt;
	logic [IDX_W-1:0]      k_q, n_q;
	logic                  in_fire, is_sample, basis_we, vec_we, len_bad;
	logic [LEN_W-1:0]      size_ext, size_m1;
	logic                  n_last, k_last, out_free, res_load, err_load;
	logic [AW-1:0]         waddr, raddr;
	mac_tag_t              tag_s1;
	logic [31:0]           b_word_s1;
	logic [2*SW-1:0]       x_word_s1;
	mac_res_t              res;
	logic                  out_valid_q;
	out_item_t             out_q;

	logic [31:0]           basis_mem [DEPTH];
	logic [2*SW-1:0]       vec_mem [MAX_POINTS];

	assign in_stall  = (state_q != ST_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign is_sample = (in_data.operation == OP_SAMPLE);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= DIR_FORWARD;
			size_q      <= SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_DIRECTION: direction_q <= cfg_data[0];
				CFG_SIZE:      size_q      <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sample count saturates one past the capacity to flag an overlong vector
	assign count_nxt = (count_q < CNT_W'(MAX_POINTS)) ? count_q + CNT_W'(1)
	                                                  : CNT_W'(MAX_POINTS + 1);
	assign size_ext  = LEN_W'(size_q);
	assign size_m1   = size_ext - LEN_W'(1);
	assign len_bad   = (size_q == '0) || (size_ext > LEN_W'(MAX_POINTS)) ||
	                   (LEN_W'(count_nxt) != size_ext);
	assign n_last    = (LEN_W'(n_q) == size_m1);
	assign k_last    = (LEN_W'(k_q) == size_m1);

	// Basis writes outside the stored range are dropped
	assign basis_we = in_fire && !is_sample &&
	                  ({3'b000, in_data.row} < 7'(MAX_POINTS)) &&
	                  ({3'b000, in_data.col} < 7'(MAX_POINTS));
	assign vec_we   = in_fire && is_sample && (count_q < CNT_W'(MAX_POINTS));
	assign waddr    = AW'(in_data.row) * AW'(MAX_POINTS) + AW'(in_data.col);
	assign raddr    = (direction_q == DIR_INVERSE)
	                ? AW'(k_q) * AW'(MAX_POINTS) + AW'(n_q)
	                : AW'(n_q) * AW'(MAX_POINTS) + AW'(k_q);

	// Basis memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (basis_we) begin
			basis_mem[waddr] <= {in_data.value_re, in_data.value_im};
		end
		b_word_s1 <= basis_mem[raddr];
	end

	// Vector memory keeps samples at their reduced width
	always_ff @(posedge clk) begin
		if (vec_we) begin
			vec_mem[count_q[IDX_W-1:0]] <= {in_data.value_re[SW-1:0],
			                                in_data.value_im[SW-1:0]};
		end
		x_word_s1 <= vec_mem[n_q];
	end

	assign out_free = !out_valid_q || !out_stall;
	assign res_load = (state_q == ST_DRAIN) && res.done && out_free;
	assign err_load = (state_q == ST_ERR) && out_free;

	// Sequencer: walk n for each k, then wait for the sum to land
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			k_q     <= '0;
			n_q     <= '0;
			tag_s1  <= '0;
		end else begin
			tag_s1.valid     <= (state_q == ST_ISSUE);
			tag_s1.first     <= (n_q == '0);
			tag_s1.last_term <= n_last;
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire && is_sample) begin
						if (in_data.last) begin
							count_q <= '0;
							k_q     <= '0;
							n_q     <= '0;
							state_q <= len_bad ? ST_ERR : ST_ISSUE;
						end else begin
							count_q <= count_nxt;
						end
					end
				end
				ST_ISSUE: begin
					if (n_last) begin
						n_q     <= '0;
						state_q <= ST_DRAIN;
					end else begin
						n_q <= n_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (res_load) begin
						if (k_last) begin
							k_q     <= '0;
							state_q <= ST_IDLE;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ERR: begin
					if (err_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	cbt_mac #(
		.MAX_POINTS (MAX_POINTS),
		.SW         (SW)
	) u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.b_word_s1 (b_word_s1),
		.x_word_s1 (x_word_s1),
		.inverse   (direction_q),
		.clear     (res_load),
		.res       (res)
	);

	// Output register: hold while stalled, refill when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load || err_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q.out_re    <= res.re;
			out_q.out_im    <= res.im;
			out_q.out_index <= OIDX_W'(k_q);
			out_q.out_last  <= k_last;
			out_q.status    <= STATUS_OK;
		end else if (err_load) begin
			out_q.out_re    <= '0;
			out_q.out_im    <= '0;
			out_q.out_index <= '0;
			out_q.out_last  <= 1'b1;
			out_q.status    <= STATUS_ERR;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> hw/rtl/cbt_port_checker.sv
module cbt_port_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_stall,
	input cbt_pkg::in_item_t   in_data,
	input logic                out_valid,
	input logic                out_stall,
	input cbt_pkg::out_item_t  out_data
);
	import cbt_pkg::*;

`include "complex_basis_transform_core_assert.svh"

	// A stalled result holds
	`CBT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "result changed under stall")

	// An error result is a lone, empty, final result
	`CBT_ASSERT_SAME(a_err_shape, out_valid && (out_data.status == STATUS_ERR), out_data.out_last && (out_data.out_index == '0) && (out_data.out_re == '0) && (out_data.out_im == '0), "malformed error result")

	// A closing sample blocks input, whether it starts a run or an error result
	`CBT_ASSERT_NEXT(a_close_stalls, in_valid && !in_stall && (in_data.operation == OP_SAMPLE) && in_data.last, in_stall, "input taken right after closing sample")

	// Input stays blocked while a run still has results to produce
	`CBT_ASSERT_SAME(a_run_blocks, out_valid && !out_data.out_last, in_stall, "input open during a run")

endmodule

bind complex_basis_transform_core cbt_port_checker u_port_checker (.*);

>>> tb/sv/tb.sv
module tb;
	import cbt_pkg::*;

	localparam int MAX_POINTS    = 16;
	localparam int SAMPLE_BITS   = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int PHASE_ITEMS   = 12;
	localparam int MAX_REPORTS   = 50;
	localparam int LIMIT_TIME    = 2_000_000;
	localparam longint RES_MAX   = (longint'(1) << (RES_W - 1)) - 1;
	localparam longint RES_MIN   = -(longint'(1) << (RES_W - 1));

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	in_item_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_item_t             out_data;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Shadow copy of the block state
	logic signed [VAL_W-1:0] basis_re [MAX_POINTS * MAX_POINTS];
	logic signed [VAL_W-1:0] basis_im [MAX_POINTS * MAX_POINTS];
	logic signed [VAL_W-1:0] vec_re [MAX_POINTS];
	logic signed [VAL_W-1:0] vec_im [MAX_POINTS];
	int                      sample_cnt;
	logic                    dir_mode;
	logic [CFG_DATA_W-1:0]   size_mode;

	out_item_t coeff_q [$];
	out_item_t coeff_head;

	int fail_count;
	int basis_writes;
	int vectors_done;
	int vectors_rejected;
	bit idle_en;
	bit hold_req;
	int hold_count;
	int stall_left;

	complex_basis_transform_core #(
		.MAX_POINTS  (MAX_POINTS),
		.SAMPLE_BITS (SAMPLE_BITS)
	) i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		#(LIMIT_TIME);
		$display("complex_basis_transform_core test failed");
		$finish;
	end

	// Round by 15 bits toward minus infinity after a half bias, then clamp
	function automatic logic signed [RES_W-1:0] round_sat(longint acc);
		longint q;
		q = (acc + 64'sd16384) >>> 15;
		if (q > RES_MAX)
			q = RES_MAX;
		if (q < RES_MIN)
			q = RES_MIN;
		return RES_W'(q);
	endfunction

	// Update the shadow state with one accepted transfer and queue its coefficients
	function automatic void predict_coeffs(in_item_t item);
		longint    acc_re, acc_im, br, bi, xr, xi;
		int        len, idx;
		out_item_t res;
		if (item.operation == OP_BASIS) begin
			idx = item.row * MAX_POINTS + item.col;
			basis_re[idx] = item.value_re;
			basis_im[idx] = item.value_im;
			basis_writes++;
			return;
		end
		if (sample_cnt < MAX_POINTS) begin
			vec_re[sample_cnt] = item.value_re;
			vec_im[sample_cnt] = item.value_im;
			sample_cnt++;
		end else begin
			sample_cnt = MAX_POINTS + 1;
		end
		if (!item.last)
			return;
		len = sample_cnt;
		sample_cnt = 0;
		// Reject a bad length or an out-of-range size with a single error coefficient
		if (size_mode == 0 || size_mode > MAX_POINTS || len != size_mode) begin
			res = '0;
			res.out_last = 1'b1;
			res.status = STATUS_ERR;
			coeff_q.push_back(res);
			vectors_rejected++;
			return;
		end
		for (int k = 0; k < len; k++) begin
			acc_re = 0;
			acc_im = 0;
			for (int n = 0; n < len; n++) begin
				idx = (dir_mode == DIR_INVERSE) ? k * MAX_POINTS + n : n * MAX_POINTS + k;
				br = basis_re[idx];
				bi = basis_im[idx];
				xr = vec_re[n];
				xi = vec_im[n];
				if (dir_mode == DIR_INVERSE) begin
					acc_re += br * xr - bi * xi;
					acc_im += br * xi + bi * xr;
				end else begin
					acc_re += br * xr + bi * xi;
					acc_im += br * xi - bi * xr;
				end
			end
			res.out_re = round_sat(acc_re);
			res.out_im = round_sat(acc_im);
			res.out_index = OIDX_W'(k);
			res.out_last = (k == len - 1);
			res.status = STATUS_OK;
			coeff_q.push_back(res);
		end
		vectors_done++;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		fail_count++;
		if (fail_count <= MAX_REPORTS)
			$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
	endtask

	// Check every output transfer against the oldest queued coefficient
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (coeff_q.size() == 0) begin
				report_mismatch("unexpected coefficient, index", out_data.out_index, -1);
			end else begin
				coeff_head = coeff_q.pop_front();
				if (out_data.out_re !== coeff_head.out_re)
					report_mismatch("out_re", out_data.out_re, coeff_head.out_re);
				if (out_data.out_im !== coeff_head.out_im)
					report_mismatch("out_im", out_data.out_im, coeff_head.out_im);
				if (out_data.out_index !== coeff_head.out_index)
					report_mismatch("out_index", out_data.out_index, coeff_head.out_index);
				if (out_data.out_last !== coeff_head.out_last)
					report_mismatch("out_last", out_data.out_last, coeff_head.out_last);
				if (out_data.status !== coeff_head.status)
					report_mismatch("status", out_data.status, coeff_head.status);
			end
		end
	end

	// Drive output stall: a long hold on request, otherwise random bursts
	always @(posedge clk) begin
		if (hold_req) begin
			out_stall <= 1'b1;
			if (hold_count == HOLD_CYCLES - 1) begin
				hold_count <= 0;
				hold_req <= 1'b0;
			end else begin
				hold_count <= hold_count + 1;
			end
		end else if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (idle_en && $urandom_range(0, 5) == 0) begin
			out_stall <= 1'b1;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b0;
		end
	end

	function automatic logic signed [VAL_W-1:0] rand_val();
		case ($urandom_range(0, 7))
			0: begin
				return 16'h8000;
			end
			1: begin
				return 16'h7FFF;
			end
			default: begin
				return VAL_W'($urandom);
			end
		endcase
	endfunction

	function automatic in_item_t make_sample(logic signed [VAL_W-1:0] re,
		logic signed [VAL_W-1:0] im, logic last);
		in_item_t item;
		item.operation = OP_SAMPLE;
		item.row = ROW_W'($urandom);
		item.col = ROW_W'($urandom);
		item.value_re = re;
		item.value_im = im;
		item.last = last;
		return item;
	endfunction

	function automatic in_item_t make_basis(logic [ROW_W-1:0] r, logic [ROW_W-1:0] c,
		logic signed [VAL_W-1:0] re, logic signed [VAL_W-1:0] im);
		in_item_t item;
		item.operation = OP_BASIS;
		item.row = r;
		item.col = c;
		item.value_re = re;
		item.value_im = im;
		item.last = 1'($urandom);
		return item;
	endfunction

	// Offer one transfer, with an optional gap first, and hold it until taken
	task automatic send_item(in_item_t item);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do
			@(posedge clk);
		while (in_stall);
		predict_coeffs(item);
	endtask

	task automatic send_vector(int len);
		for (int n = 0; n < len; n++)
			send_item(make_sample(rand_val(), rand_val(), n == len - 1));
	endtask

	task automatic send_rand_basis();
		send_item(make_basis(ROW_W'($urandom), ROW_W'($urandom), rand_val(), rand_val()));
	endtask

	// Drop valid, drain all queued coefficients, then let the core settle
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (coeff_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_DIRECTION)
			dir_mode = value[0];
		else
			size_mode = value;
	endtask

	// Fill the whole basis so that no run ever reads an unwritten entry
	task automatic test_basis_load();
		for (int r = 0; r < MAX_POINTS; r++)
			for (int c = 0; c < MAX_POINTS; c++)
				send_item(make_basis(ROW_W'(r), ROW_W'(c), rand_val(), rand_val()));
	endtask

	// Full-length forward run at the reset settings with extreme samples
	task automatic test_forward_defaults();
		logic signed [VAL_W-1:0] re, im;
		for (int n = 0; n < MAX_POINTS; n++) begin
			case (n % 4)
				0: begin
					re = 16'h8000;
					im = 16'h7FFF;
				end
				1: begin
					re = 16'h7FFF;
					im = 16'h8000;
				end
				2: begin
					re = 16'h0000;
					im = 16'hFFFF;
				end
				default: begin
					re = 16'hFFFF;
					im = 16'h0000;
				end
			endcase
			send_item(make_sample(re, im, n == MAX_POINTS - 1));
		end
		wait_idle();
	endtask

	// Single-point runs with the largest magnitude products in both directions
	task automatic test_extreme_products();
		write_reg(CFG_SIZE, 5'd1);
		send_item(make_basis('0, '0, 16'h8000, 16'h8000));
		send_item(make_sample(16'h8000, 16'h8000, 1'b1));
		send_item(make_basis('0, '0, 16'h7FFF, 16'h8000));
		send_item(make_sample(16'h8000, 16'h7FFF, 1'b1));
		write_reg(CFG_DIRECTION, CFG_DATA_W'(DIR_INVERSE));
		send_item(make_sample(16'h8000, 16'h7FFF, 1'b1));
		send_item(make_sample(16'h7FFF, 16'h7FFF, 1'b1));
		wait_idle();
	endtask

	task automatic test_inverse_small();
		write_reg(CFG_SIZE, 5'd3);
		send_vector(3);
		wait_idle();
	endtask

	// Short, long and overflowing vectors, plus sizes the core cannot run
	task automatic test_length_mismatch();
		write_reg(CFG_DIRECTION, CFG_DATA_W'(DIR_FORWARD));
		write_reg(CFG_SIZE, 5'd4);
		send_vector(2);
		send_vector(5);
		send_vector(MAX_POINTS + 2);
		write_reg(CFG_SIZE, 5'd0);
		send_vector(1);
		write_reg(CFG_SIZE, 5'd17);
		send_vector(17);
		write_reg(CFG_SIZE, 5'd31);
		send_vector(1);
		wait_idle();
	endtask

	// Hold off the receiver while vectors keep arriving so the input backs up
	task automatic test_receiver_hold();
		write_reg(CFG_SIZE, 5'd4);
		hold_req = 1'b1;
		repeat (3) begin
			send_vector(4);
			send_rand_basis();
		end
		wait_idle();
	endtask

	// Mostly well-formed vectors, some basis updates and some broken lengths
	task automatic run_random_phase(logic dir, logic [CFG_DATA_W-1:0] size, int items);
		int sent;
		int pick;
		int len;
		sent = 0;
		write_reg(CFG_DIRECTION, CFG_DATA_W'(dir));
		write_reg(CFG_SIZE, size);
		while (sent < items) begin
			pick = $urandom_range(0, 9);
			if (pick < 2) begin
				repeat ($urandom_range(1, 4)) begin
					send_rand_basis();
					sent++;
				end
			end else if (pick < 3) begin
				len = $urandom_range(1, MAX_POINTS + 2);
				send_vector(len);
				sent += len;
			end else begin
				send_vector(size);
				sent += size;
			end
		end
	endtask

	task automatic test_random_traffic();
		run_random_phase(DIR_INVERSE, 5'd3, PHASE_ITEMS);
		run_random_phase(DIR_FORWARD, 5'd1, PHASE_ITEMS);
		run_random_phase(DIR_INVERSE, 5'd16, PHASE_ITEMS);
		run_random_phase(DIR_FORWARD, 5'd5, PHASE_ITEMS);
		run_random_phase(DIR_INVERSE, 5'd8, PHASE_ITEMS);
		// Run the last part at full rate on both sides
		idle_en = 1'b0;
		run_random_phase(DIR_FORWARD, 5'd2, PHASE_ITEMS);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		dir_mode = DIR_FORWARD;
		size_mode = SIZE_RESET;
		sample_cnt = 0;
		fail_count = 0;
		basis_writes = 0;
		vectors_done = 0;
		vectors_rejected = 0;
		idle_en = 1'b1;
		hold_req = 1'b0;
		hold_count = 0;
		stall_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basis_load();
		test_forward_defaults();
		test_extreme_products();
		test_inverse_small();
		test_length_mismatch();
		test_receiver_hold();
		test_random_traffic();
		wait_idle();

		$display("covered %0d basis writes, %0d computed and %0d rejected vectors",
			basis_writes, vectors_done, vectors_rejected);
		$display("in both directions, sizes 0 to 31 with extremes, and a long output hold");
		if (fail_count == 0)
			$display("complex_basis_transform_core test passed");
		else
			$display("complex_basis_transform_core test failed");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/cbt_pkg.sv
hw/rtl/cbt_mac.sv
hw/rtl/complex_basis_transform_core.sv
hw/rtl/cbt_port_checker.sv
tb/sv/tb.sv
